/* rtl/core/mips_subset_instruction_executor_top_assert.svh */
// Assertion macros for the MIPS subset executor.
`ifndef MIPS_SUBSET_INSTRUCTION_EXECUTOR_TOP_ASSERT_SVH
`define MIPS_SUBSET_INSTRUCTION_EXECUTOR_TOP_ASSERT_SVH

`ifndef SYNTH
`define MSE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("property violated");
`define MSE_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define MSE_ASSERT(label, prop)
`define MSE_NEVER(label, cond)
`endif

`endif

/* rtl/core/mse_pkg.sv */
// Types, constants and codes shared by the MIPS subset executor.
package mse_pkg;

  localparam int DATA_WORDS = 1024;
  localparam int DW_AW      = $clog2(DATA_WORDS);
  localparam int NUM_REGS   = 32;
  localparam int REG_AW     = $clog2(NUM_REGS);
  localparam int CFG_AW     = 4;

  localparam logic [31:0] TEXT_START_RST = 32'h0040_0000;
  localparam logic [20:0] INST_COUNT_RST = 21'd0;
  localparam logic [31:0] DATA_BASE_RST  = 32'h1000_0000;

  localparam logic [1:0] REG_TEXT_START = 2'd0;
  localparam logic [1:0] REG_INST_COUNT = 2'd1;
  localparam logic [1:0] REG_DATA_BASE  = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_UNKNOWN  = 2'd1;
  localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2b;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  localparam logic [3:0]  JMP_REGION_BITS = 4'hF;
  localparam logic [REG_AW-1:0] LINK_REG  = REG_AW'(31);

  typedef struct packed {
    logic        kind;
    logic [31:0] instr_word;
    logic [9:0]  preload_index;
    logic [31:0] preload_value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic [1:0]  status;
    logic        reg_written;
    logic [4:0]  dest_reg;
    logic [31:0] dest_value;
  } out_word_t;

  typedef struct packed {
    logic [31:0]       npc;
    logic              run_next;
    logic [1:0]        status;
    logic              wr;
    logic [REG_AW-1:0] dreg;
    logic [31:0]       dval;
    logic              is_lw;
    logic              mem_we;
    logic [DW_AW-1:0]  mem_idx;
    logic [31:0]       mem_wdata;
  } exec_res_t;

endpackage

/* rtl/core/mse_regfile.sv */
// Register file with registered read ports, write bypass and operand update.
module mse_regfile (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [mse_pkg::REG_AW-1:0] raddr_a_i,
  input  logic [mse_pkg::REG_AW-1:0] raddr_b_i,
  input  logic                      we_i,
  input  logic [mse_pkg::REG_AW-1:0] waddr_i,
  input  logic [31:0]               wdata_i,
  output logic [31:0]               rdata_a_o,
  output logic [31:0]               rdata_b_o
);

  logic [31:0]                mem_q [mse_pkg::NUM_REGS];
  logic [mse_pkg::NUM_REGS-1:0] valid_q;
  logic [mse_pkg::REG_AW-1:0] ra_q;
  logic [mse_pkg::REG_AW-1:0] rb_q;
  logic [31:0]                rdata_a_q;
  logic [31:0]                rdata_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ra_q <= raddr_a_i;
      rb_q <= raddr_b_i;
      if (we_i && (waddr_i == raddr_a_i)) begin
        rdata_a_q <= wdata_i;
      end else if (valid_q[raddr_a_i]) begin
        rdata_a_q <= mem_q[raddr_a_i];
      end else begin
        rdata_a_q <= '0;
      end
      if (we_i && (waddr_i == raddr_b_i)) begin
        rdata_b_q <= wdata_i;
      end else if (valid_q[raddr_b_i]) begin
        rdata_b_q <= mem_q[raddr_b_i];
      end else begin
        rdata_b_q <= '0;
      end
    end else begin
      if (we_i && (waddr_i == ra_q)) begin
        rdata_a_q <= wdata_i;
      end
      if (we_i && (waddr_i == rb_q)) begin
        rdata_b_q <= wdata_i;
      end
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* rtl/core/mse_exec.sv */
// Decode, ALU, branch, address check and halt check for one instruction word, or the store of one preload data word.
module mse_exec (
  input  mse_pkg::in_word_t  word_i,
  input  logic [31:0]        pc_i,
  input  logic               run_i,
  input  logic [31:0]        a_i,
  input  logic [31:0]        b_i,
  input  logic [31:0]        data_base_i,
  input  logic [31:0]        end_pc_i,
  output mse_pkg::exec_res_t res_o
);

  logic [5:0]                 op;
  logic [5:0]                 fn;
  logic [mse_pkg::REG_AW-1:0] rt;
  logic [mse_pkg::REG_AW-1:0] rd;
  logic [4:0]                 sh;
  logic [15:0]                imm;
  logic [31:0]                simm;
  logic [31:0]                pc4;
  logic [31:0]                br_tgt;
  logic [31:0]                jmp_tgt;
  logic [31:0]                addr;
  logic [31:0]                off;
  logic                       addr_ok;
  logic [31:0]                pidx_ext;
  logic                       pidx_ok;
  logic                       known;
  logic                       wr;
  logic                       lw;
  logic                       sw;
  logic [mse_pkg::REG_AW-1:0] dreg;
  logic [31:0]                dval;
  logic [31:0]                npc;

  assign op      = word_i.instr_word[31:26];
  assign fn      = word_i.instr_word[5:0];
  assign rt      = word_i.instr_word[20:16];
  assign rd      = word_i.instr_word[15:11];
  assign sh      = word_i.instr_word[10:6];
  assign imm     = word_i.instr_word[15:0];
  assign simm    = {{16{imm[15]}}, imm};
  assign pc4     = pc_i + 32'd4;
  assign br_tgt  = pc4 + {simm[29:0], 2'b00};
  assign jmp_tgt = {pc4[31:28] & mse_pkg::JMP_REGION_BITS, word_i.instr_word[25:0], 2'b00};
  assign addr    = a_i + simm;
  assign off     = addr - data_base_i;
  assign addr_ok = (addr[1:0] == 2'b00) && (off[31:2] < 30'(mse_pkg::DATA_WORDS));
  assign pidx_ext = 32'(word_i.preload_index);
  assign pidx_ok  = pidx_ext < 32'(mse_pkg::DATA_WORDS);

  always_comb begin
    npc   = pc4;
    known = 1'b1;
    wr    = 1'b0;
    lw    = 1'b0;
    sw    = 1'b0;
    dreg  = '0;
    dval  = '0;
    case (op)
      mse_pkg::OP_SPECIAL: begin
        dreg = rd;
        case (fn)
          mse_pkg::FN_ADDU: begin
            wr = 1'b1; dval = a_i + b_i;
          end
          mse_pkg::FN_SUBU: begin
            wr = 1'b1; dval = a_i - b_i;
          end
          mse_pkg::FN_AND: begin
            wr = 1'b1; dval = a_i & b_i;
          end
          mse_pkg::FN_OR: begin
            wr = 1'b1; dval = a_i | b_i;
          end
          mse_pkg::FN_NOR: begin
            wr = 1'b1; dval = ~(a_i | b_i);
          end
          mse_pkg::FN_SLTU: begin
            wr = 1'b1; dval = {31'd0, a_i < b_i};
          end
          mse_pkg::FN_SLL: begin
            wr = 1'b1; dval = b_i << sh;
          end
          mse_pkg::FN_SRL: begin
            wr = 1'b1; dval = b_i >> sh;
          end
          mse_pkg::FN_JR: begin
            npc = a_i;
          end
          default: begin
            known = 1'b0;
          end
        endcase
      end
      mse_pkg::OP_ADDIU: begin
        wr = 1'b1; dreg = rt; dval = a_i + simm;
      end
      mse_pkg::OP_LUI: begin
        wr = 1'b1; dreg = rt; dval = {imm, 16'd0};
      end
      mse_pkg::OP_ORI: begin
        wr = 1'b1; dreg = rt; dval = a_i | {16'd0, imm};
      end
      mse_pkg::OP_ANDI: begin
        wr = 1'b1; dreg = rt; dval = a_i & {16'd0, imm};
      end
      mse_pkg::OP_SLTIU: begin
        wr = 1'b1; dreg = rt; dval = {31'd0, a_i < simm};
      end
      mse_pkg::OP_LW: begin
        lw = 1'b1; wr = addr_ok; dreg = rt;
      end
      mse_pkg::OP_SW: begin
        sw = 1'b1;
      end
      mse_pkg::OP_BEQ: begin
        if (a_i == b_i) begin
          npc = br_tgt;
        end
      end
      mse_pkg::OP_BNE: begin
        if (a_i != b_i) begin
          npc = br_tgt;
        end
      end
      mse_pkg::OP_J: begin
        npc = jmp_tgt;
      end
      mse_pkg::OP_JAL: begin
        wr = 1'b1; dreg = mse_pkg::LINK_REG; dval = pc4; npc = jmp_tgt;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_o           = '0;
    res_o.npc       = pc_i;
    res_o.run_next  = run_i;
    res_o.status    = mse_pkg::STATUS_OK;
    res_o.mem_idx   = off[mse_pkg::DW_AW+1:2];
    res_o.mem_wdata = b_i;
    if (word_i.kind) begin
      res_o.mem_we    = pidx_ok;
      res_o.mem_idx   = pidx_ext[mse_pkg::DW_AW-1:0];
      res_o.mem_wdata = word_i.preload_value;
    end else if (run_i) begin
      if (!known) begin
        res_o.status = mse_pkg::STATUS_UNKNOWN;
      end else begin
        res_o.npc      = npc;
        res_o.run_next = (npc != end_pc_i);
        res_o.mem_we   = sw && addr_ok;
        res_o.is_lw    = lw;
        if ((lw || sw) && !addr_ok) begin
          res_o.status = mse_pkg::STATUS_BAD_ADDR;
        end
        if (wr && (dreg != '0)) begin
          res_o.wr   = 1'b1;
          res_o.dreg = dreg;
          res_o.dval = dval;
        end
      end
    end
  end

endmodule

/* rtl/core/mips_subset_instruction_executor_top.sv */
// Top level of the MIPS subset executor: config port, pipeline and data memory.
// Executes one MIPS instruction word (or stores one preload data word) per
// accepted input word, at one word per clock while the output is not stalled;
// a result passes through the execute, memory and output registers before it
// leaves. Operands come from the register file with forwarding from the memory
// stage, so dependent instructions run back to back. After reset a clearing
// pass writes zero to all DATA_WORDS (1024) data memory words, one word per
// cycle, and in_stall_o stays high until the pass ends; configuration writes
// are taken throughout. Writing text_start also loads the PC and restarts a
// halted program; write the registers only while idle.
`include "mips_subset_instruction_executor_top_assert.svh"

module mips_subset_instruction_executor_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  mse_pkg::in_word_t          in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output mse_pkg::out_word_t         out_word_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mse_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [31:0] text_start_q;
  logic [20:0] inst_count_q;
  logic [31:0] data_base_q;
  logic [31:0] end_pc;
  logic [31:0] pc_q;
  logic        run_q;
  logic        cfg_we;
  logic        cfg_ts_we;

  logic                      clr_busy_q;
  logic [mse_pkg::DW_AW-1:0] clr_idx_q;

  logic               in_accept;
  logic               e_valid_q, e_valid_d;
  mse_pkg::in_word_t  e_word_q;
  logic               m_valid_q, m_valid_d;
  mse_pkg::exec_res_t m_q;
  logic               o_valid_q, o_valid_d;
  mse_pkg::out_word_t out_q;
  logic               m_adv;
  logic               o_adv;

  logic [31:0]        rf_a, rf_b;
  logic [31:0]        a_eff, b_eff;
  logic [31:0]        m_value;
  logic               rf_we;
  mse_pkg::exec_res_t e_res;

  logic [31:0] dmem_q [mse_pkg::DATA_WORDS];
  logic [31:0] dmem_rdata_q;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite && pready;
  assign cfg_ts_we = cfg_we && (paddr[3:2] == mse_pkg::REG_TEXT_START);

  always_comb begin
    case (paddr[3:2])
      mse_pkg::REG_TEXT_START: prdata = text_start_q;
      mse_pkg::REG_INST_COUNT: prdata = 32'(inst_count_q);
      mse_pkg::REG_DATA_BASE:  prdata = data_base_q;
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_start_q <= mse_pkg::TEXT_START_RST;
      inst_count_q <= mse_pkg::INST_COUNT_RST;
      data_base_q  <= mse_pkg::DATA_BASE_RST;
    end else begin
      if (cfg_we) begin
        case (paddr[3:2])
          mse_pkg::REG_TEXT_START: text_start_q <= pwdata;
          mse_pkg::REG_INST_COUNT: inst_count_q <= pwdata[20:0];
          mse_pkg::REG_DATA_BASE:  data_base_q  <= pwdata;
          default:                 ;
        endcase
      end
    end
  end

  assign end_pc = text_start_q + 32'({inst_count_q, 2'b00});

  // clearing pass over data memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + mse_pkg::DW_AW'(1);
      if (clr_idx_q == mse_pkg::DW_AW'(mse_pkg::DATA_WORDS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // pipeline control
  assign o_adv      = m_valid_q && (!o_valid_q || !out_stall_i);
  assign m_adv      = e_valid_q && (!m_valid_q || o_adv);
  assign in_stall_o = clr_busy_q || (e_valid_q && !m_adv);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign e_valid_d = in_accept ? 1'b1 : (m_adv ? 1'b0 : e_valid_q);
  assign m_valid_d = m_adv ? 1'b1 : (o_adv ? 1'b0 : m_valid_q);
  assign o_valid_d = o_adv ? 1'b1 : ((o_valid_q && !out_stall_i) ? 1'b0 : o_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      e_valid_q <= e_valid_d;
      m_valid_q <= m_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  // program counter and run flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= mse_pkg::TEXT_START_RST;
      run_q <= 1'b1;
    end else if (cfg_ts_we) begin
      pc_q  <= pwdata;
      run_q <= 1'b1;
    end else if (m_adv) begin
      pc_q  <= e_res.npc;
      run_q <= e_res.run_next;
    end
  end

  // execute stage
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      e_word_q <= in_word_i;
    end
  end

  assign m_value = m_q.is_lw ? dmem_rdata_q : m_q.dval;
  assign rf_we   = o_adv && m_q.wr;

  mse_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (in_accept),
    .raddr_a_i (in_word_i.instr_word[25:21]),
    .raddr_b_i (in_word_i.instr_word[20:16]),
    .we_i      (rf_we),
    .waddr_i   (m_q.dreg),
    .wdata_i   (m_value),
    .rdata_a_o (rf_a),
    .rdata_b_o (rf_b)
  );

  assign a_eff = (m_valid_q && m_q.wr && (m_q.dreg == e_word_q.instr_word[25:21]))
                 ? m_value : rf_a;
  assign b_eff = (m_valid_q && m_q.wr && (m_q.dreg == e_word_q.instr_word[20:16]))
                 ? m_value : rf_b;

  mse_exec u_exec (
    .word_i      (e_word_q),
    .pc_i        (pc_q),
    .run_i       (run_q),
    .a_i         (a_eff),
    .b_i         (b_eff),
    .data_base_i (data_base_q),
    .end_pc_i    (end_pc),
    .res_o       (e_res)
  );

  // data memory
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      dmem_q[clr_idx_q] <= '0;
    end else if (m_adv && e_res.mem_we) begin
      dmem_q[e_res.mem_idx] <= e_res.mem_wdata;
    end
    if (m_adv) begin
      dmem_rdata_q <= dmem_q[e_res.mem_idx];
    end
  end

  // memory and output stages
  always_ff @(posedge clk_i) begin
    if (m_adv) begin
      m_q <= e_res;
    end
    if (o_adv) begin
      out_q.next_pc     <= m_q.npc;
      out_q.halted      <= !m_q.run_next;
      out_q.status      <= m_q.status;
      out_q.reg_written <= m_q.wr;
      out_q.dest_reg    <= m_q.dreg;
      out_q.dest_value  <= m_q.wr ? m_value : '0;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_word_o  = out_q;

  `MSE_NEVER(a_rf_zero_write, rf_we && (m_q.dreg == '0))
  `MSE_ASSERT(a_unknown_no_write, (m_valid_q && (m_q.status == mse_pkg::STATUS_UNKNOWN)) |-> !m_q.wr)
  `MSE_NEVER(a_clear_pipe_empty, clr_busy_q && (e_valid_q || m_valid_q || o_valid_q))
  `MSE_ASSERT(a_halted_holds, (m_adv && !run_q) |-> (!e_res.wr && (e_res.npc == pc_q)))

endmodule
